// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = 32;
	localparam int ITER_W     = 12;
	localparam int NUM_W      = 64 + FRAC_BITS;
	localparam int DIV_STEPS  = NUM_W;
	localparam int SQRT_STEPS = NUM_W / 2;
	localparam int MUL_STEPS  = 4;
	localparam int CNT_W      = $clog2(NUM_W + 1);

	localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(800);

	typedef logic signed [63:0] val_t;

	localparam val_t MAXV    = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam val_t MINV    = 64'sh8000_0000_0000_0000;
	localparam val_t OUT_MAX = (64'sd1 <<< (COEF_W - 1)) - 64'sd1;
	localparam val_t OUT_MIN = -OUT_MAX - 64'sd1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_SAT  = 2'd2;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_B,
		ST_DIV_C,
		ST_DIV_D,
		ST_DIV_E,
		ST_DIV_Y,
		ST_DIV_Z,
		ST_IT_YT,
		ST_IT_ZT,
		ST_IT_DY,
		ST_IT_DZ,
		ST_FIN,
		ST_PR_MUL,
		ST_PR_SQRT,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic dz;
	} unit_rsp_t;

	typedef struct packed {
		logic              sat;
		logic [COEF_W-1:0] val;
	} out_t;

	function automatic val_t sat_add(val_t a, val_t b);
		val_t s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63]))
			return a[63] ? -MAXV : MAXV;
		else if (s == MINV)
			return -MAXV;
		else
			return s;
	endfunction

	function automatic val_t sat_sub(val_t a, val_t b);
		return sat_add(a, -b);
	endfunction

	function automatic val_t half(val_t v);
		val_t m;
		m = -v;
		return v[63] ? -(m >>> 1) : (v >>> 1);
	endfunction

	function automatic val_t times4(val_t v);
		val_t t;
		t = sat_add(v, v);
		return sat_add(t, t);
	endfunction

	function automatic out_t put_out(val_t v);
		out_t o;
		o.sat = 1'b0;
		o.val = v[COEF_W-1:0];
		if (v > OUT_MAX) begin
			o.sat = 1'b1;
			o.val = OUT_MAX[COEF_W-1:0];
		end else if (v < OUT_MIN) begin
			o.sat = 1'b1;
			o.val = OUT_MIN[COEF_W-1:0];
		end
		return o;
	endfunction

endpackage

// ===== hdl/qrs_unit.sv =====
`timescale 1ns / 1ps
// Shared multi-cycle multiply / divide / square-root unit on saturating Q-format values.
module qrs_unit import qrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	input  val_t      opa,
	input  val_t      opb,
	output unit_rsp_t rsp,
	output val_t      res
);

	logic             busy_q, done_q, dz_q, neg_q;
	op_t              op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [62:0]      ma_q, mb_q;
	logic [NUM_W-1:0] num_q;
	logic [63:0]      rem_q;
	logic [127:0]     acc_q;
	val_t             res_q;

	logic [62:0]  ma, mb;
	logic         last;
	logic [31:0]  ap, bp;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [63:0]  drem, srem, strial;
	logic         dge, sge;
	val_t         fin_v;

	assign ma = opa[63] ? 63'(-opa) : opa[62:0];
	assign mb = opb[63] ? 63'(-opb) : opb[62:0];

	always_comb begin
		case (op_q)
			OP_MUL:  last = (cnt_q == CNT_W'(MUL_STEPS));
			OP_DIV:  last = (cnt_q == CNT_W'(DIV_STEPS));
			default: last = (cnt_q == CNT_W'(SQRT_STEPS));
		endcase
	end

	// one 32x32 partial product per cycle
	assign ap = cnt_q[1] ? {1'b0, ma_q[62:32]} : ma_q[31:0];
	assign bp = cnt_q[0] ? {1'b0, mb_q[62:32]} : mb_q[31:0];
	assign pp = ap * bp;
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// restoring division, one quotient bit per cycle
	assign drem = {rem_q[62:0], num_q[NUM_W-1]};
	assign dge  = drem >= {1'b0, mb_q};

	// digit-by-digit root, two radicand bits per cycle
	assign srem   = {rem_q[61:0], num_q[NUM_W-1 -: 2]};
	assign strial = {acc_q[61:0], 2'b01};
	assign sge    = srem >= strial;

	always_comb begin
		case (op_q)
			OP_MUL:
				fin_v = (acc_q[127:63+FRAC_BITS] != '0) ? MAXV
					: val_t'(acc_q[62+FRAC_BITS:FRAC_BITS]);
			OP_DIV:
				fin_v = (acc_q[NUM_W-1:63] != '0) ? MAXV : val_t'(acc_q[62:0]);
			default:
				fin_v = val_t'(acc_q[62:0]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.op == OP_DIV && mb == '0)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			neg_q <= (req.op != OP_SQRT) && (opa[63] != opb[63]);
			ma_q  <= ma;
			mb_q  <= mb;
			num_q <= {1'b0, ma, FRAC_BITS'(0)};
			rem_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			dz_q  <= (req.op == OP_DIV) && (mb == '0);
			res_q <= '0;
		end else if (busy_q) begin
			if (last) begin
				res_q <= neg_q ? -fin_v : fin_v;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				case (op_q)
					OP_MUL: acc_q <= acc_q + pp_sh;
					OP_DIV: begin
						num_q <= num_q << 1;
						rem_q <= dge ? drem - {1'b0, mb_q} : drem;
						acc_q <= {acc_q[126:0], dge};
					end
					default: begin
						num_q <= num_q << 2;
						rem_q <= sge ? srem - strial : srem;
						acc_q <= {acc_q[126:0], sge};
					end
				endcase
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.dz   = dz_q;
	assign res      = res_q;

endmodule

// ===== hdl/quartic_root_solver_core.sv =====
`timescale 1ns / 1ps
// Quartic roots by Lin-Bairstow factorisation on one shared multi-cycle unit.
// Steps: divisions normalising by the leading term, divisions for the starting factor, then per
// iteration multiplies and divisions, a final multiply, and a multiply and a root per quadratic.
// Throughput: one transaction at a time; a new one is taken once the last is in the output register.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, iteration count 800.
module quartic_root_solver_core import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ITER_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [COEF_W-1:0] coef_quartic,
	input  logic signed [COEF_W-1:0] coef_cubic,
	input  logic signed [COEF_W-1:0] coef_quadratic,
	input  logic signed [COEF_W-1:0] coef_linear,
	input  logic signed [COEF_W-1:0] coef_constant,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [COEF_W-1:0] root1_real,
	output logic signed [COEF_W-1:0] root1_imag,
	output logic signed [COEF_W-1:0] root2_real,
	output logic signed [COEF_W-1:0] root2_imag,
	output logic signed [COEF_W-1:0] root3_real,
	output logic signed [COEF_W-1:0] root3_imag,
	output logic signed [COEF_W-1:0] root4_real,
	output logic signed [COEF_W-1:0] root4_imag,
	output logic [1:0]               status
);

	`include "assert_macros.svh"

	// control
	st_t               state_q, state_d;
	logic              pend_q;
	logic              out_valid_q;
	logic [ITER_W-1:0] iter_cfg_q;
	logic              in_acc, out_load;

	// datapath registers
	val_t              b_q, c_q, d_q, e_q, y_q, z_q, q_q, r_q, den_q, n_q, delta_q;
	// leading coefficient is kept as the divisor of the normalising steps
	val_t              coef_quartic_q;
	logic [ITER_W-1:0] iter_left_q;
	logic              zero_q, pair_q, sat_q;
	logic [COEF_W-1:0] rt_q [8];
	logic [COEF_W-1:0] ort_q [8];
	logic [1:0]        status_q;

	// shared unit
	unit_req_t ureq;
	unit_rsp_t ursp;
	val_t      ua, ub, ures;

	// per-step combinational values
	val_t t_c, den_c, bq_c, cq_c, nb_c, delta_c;
	val_t re1_c, im1_c, re2_c, im2_c;
	out_t o_re1, o_im1, o_re2, o_im2;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	qrs_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.opa    (ua),
		.opb    (ub),
		.rsp    (ursp),
		.res    (ures)
	);

	// t = b - y; den = (c - z) - y*t; the same form gives r on the final step
	assign t_c   = sat_sub(b_q, y_q);
	assign den_c = sat_sub(sat_sub(c_q, z_q), ures);

	// current quadratic: s^2 + q*s + r first, then s^2 + y*s + z
	assign bq_c    = pair_q ? y_q : q_q;
	assign cq_c    = pair_q ? z_q : r_q;
	assign nb_c    = -bq_c;
	assign delta_c = sat_sub(ures, times4(cq_c));

	always_comb begin
		if (delta_q[63]) begin
			re1_c = half(nb_c);
			im1_c = half(ures);
			re2_c = re1_c;
			im2_c = -im1_c;
		end else begin
			re1_c = half(sat_add(nb_c, ures));
			im1_c = '0;
			re2_c = half(sat_sub(nb_c, ures));
			im2_c = '0;
		end
	end

	assign o_re1 = put_out(re1_c);
	assign o_im1 = put_out(im1_c);
	assign o_re2 = put_out(re2_c);
	assign o_im2 = put_out(im2_c);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_acc)
					state_d = (coef_quartic == '0) ? ST_OUT : ST_DIV_B;
			ST_DIV_B: if (ursp.done) state_d = ST_DIV_C;
			ST_DIV_C: if (ursp.done) state_d = ST_DIV_D;
			ST_DIV_D: if (ursp.done) state_d = ST_DIV_E;
			ST_DIV_E: if (ursp.done) state_d = ST_DIV_Y;
			ST_DIV_Y: if (ursp.done) state_d = ursp.dz ? ST_OUT : ST_DIV_Z;
			ST_DIV_Z:
				if (ursp.done)
					state_d = (iter_cfg_q == '0) ? ST_FIN : ST_IT_YT;
			ST_IT_YT: if (ursp.done) state_d = (den_c == '0) ? ST_OUT : ST_IT_ZT;
			ST_IT_ZT: if (ursp.done) state_d = ST_IT_DY;
			ST_IT_DY: if (ursp.done) state_d = ST_IT_DZ;
			ST_IT_DZ:
				if (ursp.done)
					state_d = (iter_left_q == ITER_W'(1)) ? ST_FIN : ST_IT_YT;
			ST_FIN:     if (ursp.done) state_d = ST_PR_MUL;
			ST_PR_MUL:  if (ursp.done) state_d = ST_PR_SQRT;
			ST_PR_SQRT: if (ursp.done) state_d = pair_q ? ST_OUT : ST_PR_MUL;
			ST_OUT:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit requests: issue once per step, then wait for done
	always_comb begin
		ureq.start = 1'b0;
		ureq.op    = OP_DIV;
		ua         = '0;
		ub         = '0;
		case (state_q)
			ST_DIV_B: begin ua = b_q; ub = val_t'(coef_quartic_q); end
			ST_DIV_C: begin ua = c_q; ub = val_t'(coef_quartic_q); end
			ST_DIV_D: begin ua = d_q; ub = val_t'(coef_quartic_q); end
			ST_DIV_E: begin ua = e_q; ub = val_t'(coef_quartic_q); end
			ST_DIV_Y: begin ua = d_q; ub = c_q; end
			ST_DIV_Z: begin ua = e_q; ub = c_q; end
			ST_IT_YT: begin ureq.op = OP_MUL; ua = y_q; ub = t_c; end
			ST_IT_ZT: begin ureq.op = OP_MUL; ua = z_q; ub = t_c; end
			ST_IT_DY: begin ua = n_q; ub = den_q; end
			ST_IT_DZ: begin ua = e_q; ub = den_q; end
			ST_FIN:   begin ureq.op = OP_MUL; ua = y_q; ub = t_c; end
			ST_PR_MUL: begin ureq.op = OP_MUL; ua = bq_c; ub = bq_c; end
			ST_PR_SQRT: begin
				ureq.op = OP_SQRT;
				ua      = delta_q[63] ? -delta_q : delta_q;
			end
			default: ;
		endcase
		ureq.start = (state_q != ST_IDLE) && (state_q != ST_OUT) && !pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			iter_cfg_q  <= ITER_RESET;
		end else begin
			state_q <= state_d;
			if (ureq.start)
				pend_q <= 1'b1;
			else if (ursp.done)
				pend_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we)
				iter_cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			coef_quartic_q <= val_t'(coef_quartic);
			b_q            <= val_t'(coef_cubic);
			c_q            <= val_t'(coef_quadratic);
			d_q            <= val_t'(coef_linear);
			e_q            <= val_t'(coef_constant);
			zero_q         <= (coef_quartic == '0);
			pair_q         <= 1'b0;
			sat_q          <= 1'b0;
		end
		if (ursp.done) begin
			case (state_q)
				ST_DIV_B: b_q <= ures;
				ST_DIV_C: c_q <= ures;
				ST_DIV_D: d_q <= ures;
				ST_DIV_E: e_q <= ures;
				ST_DIV_Y: begin
					y_q    <= ures;
					zero_q <= ursp.dz;
				end
				ST_DIV_Z: begin
					z_q         <= ures;
					iter_left_q <= iter_cfg_q;
				end
				ST_IT_YT: begin
					den_q  <= den_c;
					zero_q <= (den_c == '0);
				end
				ST_IT_ZT: n_q <= sat_sub(d_q, ures);
				ST_IT_DY: y_q <= ures;
				ST_IT_DZ: begin
					z_q         <= ures;
					iter_left_q <= iter_left_q - 1'b1;
				end
				ST_FIN: begin
					q_q <= t_c;
					r_q <= den_c;
				end
				ST_PR_MUL: delta_q <= delta_c;
				ST_PR_SQRT: begin
					rt_q[{pair_q, 2'd0}] <= o_re1.val;
					rt_q[{pair_q, 2'd1}] <= o_im1.val;
					rt_q[{pair_q, 2'd2}] <= o_re2.val;
					rt_q[{pair_q, 2'd3}] <= o_im2.val;
					sat_q  <= sat_q | o_re1.sat | o_im1.sat | o_re2.sat | o_im2.sat;
					pair_q <= 1'b1;
				end
				default: ;
			endcase
		end
		if (out_load) begin
			for (int i = 0; i < 8; i++)
				ort_q[i] <= zero_q ? '0 : rt_q[i];
			status_q <= zero_q ? STATUS_ZERO : (sat_q ? STATUS_SAT : STATUS_OK);
		end
	end

	assign out_valid  = out_valid_q;
	assign root1_real = ort_q[0];
	assign root1_imag = ort_q[1];
	assign root2_real = ort_q[2];
	assign root2_imag = ort_q[3];
	assign root3_real = ort_q[4];
	assign root3_imag = ort_q[5];
	assign root4_real = ort_q[6];
	assign root4_imag = ort_q[7];
	assign status     = status_q;

	// a transaction always leaves idle
	`ASSERT_NEXT(a_acc_leaves_idle, clk, arst_n, in_acc, state_q != ST_IDLE, "accepted transaction left sequencer idle")
	// never start the shared unit while it is still working
	`ASSERT_IMPLY(a_no_overlap, clk, arst_n, ureq.start, !ursp.busy, "shared unit restarted while busy")
	// refinement loop never runs with an exhausted counter
	`ASSERT_IMPLY(a_iter_live, clk, arst_n, state_q == ST_IT_DZ, iter_left_q != '0, "refinement counter underflow")
	// a zero divisor yields all-zero roots; checked on root1_real, root1_imag, root3_real and root4_real
	`ASSERT_IMPLY(a_zero_roots, clk, arst_n, out_valid_q && (status_q == STATUS_ZERO), (ort_q[0] == '0) && (ort_q[1] == '0) && (ort_q[4] == '0) && (ort_q[6] == '0), "zero-divisor result carries roots")

endmodule

// ===== bench/qrs_checker.sv =====
`timescale 1ns / 1ps
module qrs_checker import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ITER_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [COEF_W-1:0] coef_quartic,
	input  logic signed [COEF_W-1:0] coef_cubic,
	input  logic signed [COEF_W-1:0] coef_quadratic,
	input  logic signed [COEF_W-1:0] coef_linear,
	input  logic signed [COEF_W-1:0] coef_constant,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [COEF_W-1:0] root1_real,
	input  logic signed [COEF_W-1:0] root1_imag,
	input  logic signed [COEF_W-1:0] root2_real,
	input  logic signed [COEF_W-1:0] root2_imag,
	input  logic signed [COEF_W-1:0] root3_real,
	input  logic signed [COEF_W-1:0] root3_imag,
	input  logic signed [COEF_W-1:0] root4_real,
	input  logic signed [COEF_W-1:0] root4_imag,
	input  logic [1:0]               status,
	output int                       roots_pending,
	output int                       mismatches
);

	localparam longint LIM = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [7:0][COEF_W-1:0] root;
		logic [1:0]             status;
	} roots_t;

	roots_t            roots_q[$];
	logic [ITER_W-1:0] iters;

	function automatic logic [63:0] magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint from_mag(logic [63:0] m, bit neg);
		longint v;
		v = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? LIM : longint'(m);
		return neg ? -v : v;
	endfunction

	function automatic longint sum_sat(longint a, longint b);
		if (b > 0 && a > LIM - b) return LIM;
		if (b < 0 && a < -LIM - b) return -LIM;
		return a + b;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> FRAC_BITS;
		if (p[127:64] != 0) p[63:0] = '1;
		return from_mag(p[63:0], (a < 0) != (b < 0));
	endfunction

	function automatic longint fx_div(longint a, longint b, inout bit dz);
		logic [127:0] q;
		if (b == 0) begin
			dz = 1'b1;
			return 0;
		end
		q = ({64'd0, magn(a)} << FRAC_BITS) / {64'd0, magn(b)};
		if (q[127:64] != 0) q[63:0] = '1;
		return from_mag(q[63:0], (a < 0) != (b < 0));
	endfunction

	// floor of the root of v scaled up by the fraction bits
	function automatic longint fx_sqrt(longint v);
		logic [127:0] n;
		logic [63:0]  r, t;
		n = {64'd0, magn(v)} << FRAC_BITS;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if ({64'd0, t} * {64'd0, t} <= n) r = t;
		end
		return from_mag(r, 1'b0);
	endfunction

	function automatic longint halve(longint v);
		return v < 0 ? -longint'(magn(v) >> 1) : v >>> 1;
	endfunction

	function automatic logic [COEF_W-1:0] clip(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			v = 64'sd2147483647;
			sat = 1'b1;
		end
		if (v < -64'sd2147483648) begin
			v = -64'sd2147483648;
			sat = 1'b1;
		end
		return v[COEF_W-1:0];
	endfunction

	function automatic logic [3:0][COEF_W-1:0] pair_roots(longint bq, longint cq, inout bit sat);
		logic [3:0][COEF_W-1:0] o;
		longint disc, fq, re, im, s;
		fq = sum_sat(cq, cq);
		fq = sum_sat(fq, fq);
		disc = sum_sat(fx_mul(bq, bq), -fq);
		if (disc < 0) begin
			re = halve(-bq);
			im = halve(fx_sqrt(-disc));
			o[0] = clip(re, sat);
			o[1] = clip(im, sat);
			o[2] = clip(re, sat);
			o[3] = clip(-im, sat);
		end else begin
			s = fx_sqrt(disc);
			o[0] = clip(halve(sum_sat(-bq, s)), sat);
			o[1] = 0;
			o[2] = clip(halve(sum_sat(-bq, -s)), sat);
			o[3] = 0;
		end
		return o;
	endfunction

	function automatic roots_t solve_quartic(longint a, longint b, longint c, longint d,
			longint e, logic [ITER_W-1:0] n);
		roots_t r;
		longint y, z, q, rr, t, den, yn, zn;
		bit dz, sat;
		logic [3:0][COEF_W-1:0] lo, hi;
		r = '0;
		dz = 1'b0;
		sat = 1'b0;
		if (a == 0) begin
			r.status = STATUS_ZERO;
			return r;
		end
		b = fx_div(b, a, dz);
		c = fx_div(c, a, dz);
		d = fx_div(d, a, dz);
		e = fx_div(e, a, dz);
		y = fx_div(d, c, dz);
		z = fx_div(e, c, dz);
		for (int i = 0; i < n && !dz; i++) begin
			t = sum_sat(b, -y);
			den = sum_sat(sum_sat(c, -z), -fx_mul(y, t));
			yn = fx_div(sum_sat(d, -fx_mul(z, t)), den, dz);
			zn = fx_div(e, den, dz);
			y = yn;
			z = zn;
		end
		if (dz) begin
			r.status = STATUS_ZERO;
			return r;
		end
		q = sum_sat(b, -y);
		rr = sum_sat(sum_sat(c, -z), -fx_mul(y, q));
		lo = pair_roots(q, rr, sat);
		hi = pair_roots(y, z, sat);
		for (int k = 0; k < 4; k++) begin
			r.root[k] = lo[k];
			r.root[k+4] = hi[k];
		end
		r.status = sat ? STATUS_SAT : STATUS_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		roots_t want, got;
		if (!arst_n) begin
			iters <= ITER_RESET;
			roots_q.delete();
			roots_pending <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) iters <= cfg_wdata;
			if (in_valid && !in_stall)
				roots_q.push_back(solve_quartic(coef_quartic, coef_cubic, coef_quadratic,
					coef_linear, coef_constant, iters));
			if (out_valid && !out_stall) begin
				got.root = {root4_imag, root4_real, root3_imag, root3_real,
					root2_imag, root2_real, root1_imag, root1_real};
				got.status = status;
				if (roots_q.size() == 0) begin
					if (mismatches < 10) $display("unexpected result transaction: %h", got);
					mismatches <= mismatches + 1;
				end else begin
					want = roots_q.pop_front();
					if (want != got) begin
						if (mismatches < 10) begin
							for (int k = 0; k < 8; k++)
								if (want.root[k] != got.root[k])
									$display("root field %0d: expected %h, got %h",
										k, want.root[k], got.root[k]);
							if (want.status != got.status)
								$display("status: expected %0d, got %0d",
									want.status, got.status);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			roots_pending <= roots_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import qrs_pkg::*;

	localparam logic [31:0] ONE = 32'h0001_0000;   // 1.0 in Q16.16

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [ITER_W-1:0]        cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [COEF_W-1:0] coef_quartic = '0;
	logic signed [COEF_W-1:0] coef_cubic = '0;
	logic signed [COEF_W-1:0] coef_quadratic = '0;
	logic signed [COEF_W-1:0] coef_linear = '0;
	logic signed [COEF_W-1:0] coef_constant = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [COEF_W-1:0] root1_real, root1_imag, root2_real, root2_imag;
	logic signed [COEF_W-1:0] root3_real, root3_imag, root4_real, root4_imag;
	logic [1:0]               status;
	int                       roots_pending;
	int                       mismatches;
	int                       hold_req = 0;   // bumped to ask the receiver for a long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quartic_root_solver_core dut (.*);
	qrs_checker chk (.*);

	// Receiver: stall pattern changes mode every so often; a long hold-off on request
	// lets the core fill its output register and push back on the input.
	initial begin
		int mode, left, hold_seen, hold_left;
		mode = 0;
		left = 0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 4000;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(50, 400);
			end
			left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= ($urandom_range(0, 9) == 0);
				endcase
		end
	end

	// One transaction; valid stays high across back-to-back items inside a burst.
	int burst_left = 0;

	task automatic send_poly(logic [31:0] a, b, c, d, e);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		coef_quartic <= a;
		coef_cubic <= b;
		coef_quadratic <= c;
		coef_linear <= d;
		coef_constant <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (roots_pending != 0) @(posedge clk);
	endtask

	// Register writes only with the core idle.
	task automatic set_iters(logic [ITER_W-1:0] n);
		wait_drained();
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Product of two quadratics with small integer coefficients: well-conditioned input
	// that gets the refinement going; every coefficient is scaled by the same small integer.
	task automatic send_factored();
		int p, q, y, z, k;
		p = $urandom_range(0, 16) - 8;
		q = $urandom_range(0, 16) - 8;
		y = $urandom_range(0, 16) - 8;
		z = $urandom_range(0, 16) - 8;
		k = $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
		send_poly(k * ONE, k * (p + y) * ONE, k * (q + z + p * y) * ONE,
			k * (p * z + q * y) * ONE, k * q * z * ONE);
	endtask

	task automatic send_random(int cnt);
		repeat (cnt) begin
			case ($urandom_range(0, 9))
			0, 1: send_poly($urandom, $urandom, $urandom, $urandom, $urandom);
			2: send_poly($urandom_range(0, 1) ? ONE : $urandom, $urandom, $urandom,
				$urandom & 32'h000F_FFFF, $urandom & 32'h000F_FFFF);
			default: send_factored();
			endcase
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest count: a single transaction, it is the slowest by far.
		set_iters(4095);
		send_factored();

		set_iters(1);
		// Directed: zero leading term, c vanishing after normalisation, zero
		// denominator in the first step, extremes, complex pairs, saturating roots.
		send_poly(32'h0, ONE, ONE, ONE, ONE);
		send_poly(32'h7FFF_FFFF, ONE, 32'h1, ONE, ONE);
		send_poly(ONE, 32'h0, ONE, 32'h0, ONE);
		send_poly(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_poly(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_poly(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_poly(32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_poly(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
		send_poly(ONE, 2 * ONE, 6 * ONE, 2 * ONE, 5 * ONE);
		send_poly(ONE, 32'h0, -5 * ONE, 32'h0, 4 * ONE);
		send_poly(ONE, 32'h0, 2 * ONE, 32'h0, ONE);
		send_poly(32'h1, ONE, ONE, ONE, 32'h7FFF_0000);
		send_poly(32'h1, 32'h0, ONE, 32'h7FFF_FFFF, 32'h8000_0000);
		send_poly(ONE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		send_poly(-ONE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

		// Receiver holds off while the sender keeps offering: the core backs up.
		hold_req++;
		send_random(30);
		// Sender pauses until every result is back.
		wait_drained();
		send_random(10);

		set_iters(3);
		send_random(30);

		set_iters(12);
		hold_req++;
		send_random(25);

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
